/* rtl/e2r_pkg.sv */
// e2r_pkg: constants, types and the arctangent table for the Euler angle to
// rotation matrix core. Depends on nothing; every other file imports it.
package e2r_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int CORDIC_STAGES   = 16;

    localparam int IN_W      = 18;
    localparam int OUT_W     = 16;
    localparam int NUM_ANG   = 3;
    localparam int WORK_FRAC = 30;
    localparam int XY_W      = 32;
    localparam int STG_W     = 5;

    // lane codes
    localparam int YAW   = 0;
    localparam int PITCH = 1;
    localparam int ROLL  = 2;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // one turn is 45 << TURN_SH; binary angle = floor(((m << (32-TURN_SH)) + 22) / 45)
    localparam int TURN_SH = ANGLE_FRAC_BITS + 3;
    localparam int TURN    = 45 << TURN_SH;
    localparam int M_W     = TURN_SH + 6;
    localparam int WRAP_W  = M_W + 3;

    localparam int DIV1_SH = TURN_SH + 12;
    localparam int DIV1_W  = TURN_SH + 7;
    localparam logic [DIV1_W-1:0] DIV1_K = DIV1_W'(((64'd1 << DIV1_SH) / 45) + 1);
    localparam int A_W     = TURN_SH;
    localparam int B_W     = 6;

    localparam int Q2_W    = 32 - TURN_SH;
    localparam int T_W     = 38 - TURN_SH;
    localparam int DIV2_SH = 44 - TURN_SH;
    localparam int DIV2_W  = 39 - TURN_SH;
    localparam logic [DIV2_W-1:0] DIV2_K = DIV2_W'(((64'd1 << DIV2_SH) / 45) + 1);
    localparam int HALF_TURN_FLOOR = 22;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    localparam int FIN_SH  = 2 * WORK_FRAC - OUT_FRAC_BITS;
    localparam int FIN_W   = 64 - FIN_SH;
    localparam int OUT_LIM = 1 << OUT_FRAC_BITS;

    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = FIFO_AW + 1;

    localparam int ANG_LAT  = 4;
    localparam int MAT_LAT  = 6;
    localparam int PIPE_LAT = ANG_LAT + CORDIC_STAGES + MAT_LAT;

    typedef logic signed [IN_W-1:0]  t_ang;
    typedef logic signed [OUT_W-1:0] t_ent;
    typedef logic signed [XY_W-1:0]  t_xy;
    typedef logic signed [63:0]      t_q60;
    typedef logic [STG_W-1:0]        t_stg;

    typedef struct {
        t_xy        x    [NUM_ANG];
        t_xy        y    [NUM_ANG];
        t_xy        z    [NUM_ANG];
        logic [1:0] quad [NUM_ANG];
    } t_cstage;

    typedef struct packed {
        t_ent m00;
        t_ent m01;
        t_ent m02;
        t_ent m10;
        t_ent m11;
        t_ent m12;
        t_ent m20;
        t_ent m21;
        t_ent m22;
    } t_mat;

endpackage

/* rtl/e2r_if.sv */
// e2r_in_if / e2r_out_if: valid-ready channels for angle and matrix transactions.
// Depends on e2r_pkg.
interface e2r_in_if;
    import e2r_pkg::*;
    logic valid;
    logic ready;
    t_ang yaw_angle;
    t_ang pitch_angle;
    t_ang roll_angle;
    modport source (output valid, output yaw_angle, output pitch_angle,
                    output roll_angle, input ready);
    modport sink   (input valid, input yaw_angle, input pitch_angle,
                    input roll_angle, output ready);
endinterface

interface e2r_out_if;
    import e2r_pkg::*;
    logic valid;
    logic ready;
    t_ent m00;
    t_ent m01;
    t_ent m02;
    t_ent m10;
    t_ent m11;
    t_ent m12;
    t_ent m20;
    t_ent m21;
    t_ent m22;
    modport source (output valid, output m00, output m01, output m02, output m10,
                    output m11, output m12, output m20, output m21, output m22,
                    input ready);
    modport sink   (input valid, input m00, input m01, input m02, input m10,
                    input m11, input m12, input m20, input m21, input m22,
                    output ready);
endinterface

/* rtl/euler_to_rotation_matrix_core.sv */
// euler_to_rotation_matrix_core: Z-Y-X angles to 3x3 rotation matrix, Q2.14.
// Depends on e2r_pkg, e2r_if, e2r_angle, e2r_cordic_cell, e2r_matrix, e2r_obuf.
//
//   port   dir  transaction payload
//   i_in   in   yaw/pitch/roll angle, degrees, 8 fraction bits
//   o_out  out  m00..m22, signed Q2.14
//
// One transaction per cycle sustained while i_in.ready is high; the path to the FIFO is
// 4 angle stages, 16 CORDIC cells and 6 matrix stages, followed by the FIFO write and the
// output register.
// The pipeline never stalls; a 64-entry result FIFO absorbs back-pressure and
// i_in.ready drops once 64 transactions are open.
// Synchronous active-low reset clears valids, pointers and the credit count.
module euler_to_rotation_matrix_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    e2r_in_if.sink     i_in,
    e2r_out_if.source  o_out
);
    import e2r_pkg::*;

    logic    w_acc;
    logic    w_room;
    t_ang    w_ang     [NUM_ANG];
    t_cstage w_chain   [CORDIC_STAGES+1];
    logic    w_chain_v [CORDIC_STAGES+1];
    logic    w_res_v;
    t_mat    w_res;

    assign w_ang[YAW]   = i_in.yaw_angle;
    assign w_ang[PITCH] = i_in.pitch_angle;
    assign w_ang[ROLL]  = i_in.roll_angle;
    assign i_in.ready   = w_room;
    assign w_acc        = i_in.valid && w_room;

    e2r_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_angle (w_ang),
        .o_valid (w_chain_v[0]),
        .o_data  (w_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        e2r_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STG_W'(g)),
            .i_valid (w_chain_v[g]),
            .i_data  (w_chain[g]),
            .o_valid (w_chain_v[g+1]),
            .o_data  (w_chain[g+1])
        );
    end

    e2r_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_chain_v[CORDIC_STAGES]),
        .i_data  (w_chain[CORDIC_STAGES]),
        .o_valid (w_res_v),
        .o_mat   (w_res)
    );

    e2r_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_acc),
        .i_wr     (w_res_v),
        .i_data   (w_res),
        .o_room   (w_room),
        .o_out    (o_out)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##PIPE_LAT w_res_v)
        else $error("result missing after pipeline latency");

    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input blocked with no result on offer");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.m02 <= OUT_LIM && o_out.m02 >= -OUT_LIM &&
                         o_out.m11 <= OUT_LIM && o_out.m11 >= -OUT_LIM))
        else $error("matrix entry outside saturation range");

endmodule

/* rtl/e2r_angle.sv */
// e2r_angle: wraps each angle into one turn and forms the binary angle, four stages.
// Depends on e2r_pkg; feeds the first CORDIC cell.
module e2r_angle (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  e2r_pkg::t_ang     i_angle [e2r_pkg::NUM_ANG],
    output logic              o_valid,
    output e2r_pkg::t_cstage  o_data
);
    import e2r_pkg::*;

    localparam logic signed [WRAP_W-1:0] TURN_S = WRAP_W'(TURN);
    localparam int P1_W = M_W + DIV1_W;
    localparam int P2_W = T_W + DIV2_W;

    logic signed [WRAP_W-1:0] w_v   [NUM_ANG];
    logic [M_W-1:0]           n_m   [NUM_ANG];
    logic [M_W-1:0]           r_m   [NUM_ANG];
    logic [M_W-1:0]           r_m2  [NUM_ANG];
    logic [P1_W-1:0]          r_p1  [NUM_ANG];
    logic [A_W-1:0]           n_a   [NUM_ANG];
    logic [A_W-1:0]           r_a   [NUM_ANG];
    logic [A_W-1:0]           r_a2  [NUM_ANG];
    logic [M_W-1:0]           w_a45 [NUM_ANG];
    logic [B_W-1:0]           n_b   [NUM_ANG];
    logic [B_W-1:0]           r_b   [NUM_ANG];
    logic [T_W-1:0]           w_t   [NUM_ANG];
    logic [P2_W-1:0]          r_p2  [NUM_ANG];
    logic [31:0]              w_p   [NUM_ANG];
    logic [ANG_LAT-1:0]       r_vld;

    always_comb begin
        for (int k = 0; k < NUM_ANG; k++) begin
            w_v[k] = WRAP_W'(i_angle[k]);
            priority if (w_v[k] + TURN_S < 0) begin
                n_m[k] = M_W'(w_v[k] + TURN_S + TURN_S);
            end else if (w_v[k] < 0) begin
                n_m[k] = M_W'(w_v[k] + TURN_S);
            end else if (w_v[k] >= TURN_S) begin
                n_m[k] = M_W'(w_v[k] - TURN_S);
            end else begin
                n_m[k] = M_W'(w_v[k]);
            end
            // m = 45a + b
            n_a[k]   = r_p1[k][DIV1_SH +: A_W];
            w_a45[k] = M_W'(n_a[k]) * M_W'(45);
            n_b[k]   = B_W'(r_m2[k] - w_a45[k]);
            w_t[k]   = {r_b[k], Q2_W'(0)} + T_W'(HALF_TURN_FLOOR);
            w_p[k]   = {r_a2[k], r_p2[k][DIV2_SH +: Q2_W]};
            o_data.x[k]    = CORDIC_GAIN;
            o_data.y[k]    = '0;
            o_data.z[k]    = {2'b00, w_p[k][29:0]};
            o_data.quad[k] = w_p[k][31:30];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= n_m;
        r_m2 <= r_m;
        r_a  <= n_a;
        r_b  <= n_b;
        r_a2 <= r_a;
        for (int k = 0; k < NUM_ANG; k++) begin
            r_p1[k] <= P1_W'(r_m[k]) * P1_W'(DIV1_K);
            r_p2[k] <= P2_W'(w_t[k]) * P2_W'(DIV2_K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ANG_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[ANG_LAT-1];

endmodule

/* rtl/e2r_cordic_cell.sv */
// e2r_cordic_cell: one CORDIC rotation step for the three angle lanes.
// Depends on e2r_pkg; chained in the top level, one cell per stage.
module e2r_cordic_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  e2r_pkg::t_stg     i_stage,
    input  logic              i_valid,
    input  e2r_pkg::t_cstage  i_data,
    output logic              o_valid,
    output e2r_pkg::t_cstage  o_data
);
    import e2r_pkg::*;

    t_xy     w_atan;
    t_xy     w_xs [NUM_ANG];
    t_xy     w_ys [NUM_ANG];
    t_cstage n_data;
    t_cstage r_data;
    logic    r_valid;

    always_comb begin
        w_atan      = {2'b00, ATAN_TAB[i_stage]};
        n_data.quad = i_data.quad;
        for (int k = 0; k < NUM_ANG; k++) begin
            w_xs[k] = i_data.x[k] >>> i_stage;
            w_ys[k] = i_data.y[k] >>> i_stage;
            if (!i_data.z[k][XY_W-1]) begin
                n_data.x[k] = i_data.x[k] - w_ys[k];
                n_data.y[k] = i_data.y[k] + w_xs[k];
                n_data.z[k] = i_data.z[k] - w_atan;
            end else begin
                n_data.x[k] = i_data.x[k] + w_ys[k];
                n_data.y[k] = i_data.y[k] - w_xs[k];
                n_data.z[k] = i_data.z[k] + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/e2r_matrix.sv */
// e2r_matrix: quadrant fold, products, sums, rounding and saturation, six stages.
// Depends on e2r_pkg; takes the last CORDIC cell, feeds the output buffer.
module e2r_matrix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  e2r_pkg::t_cstage  i_data,
    output logic              o_valid,
    output e2r_pkg::t_mat     o_mat
);
    import e2r_pkg::*;

    localparam int P_CBCA = 0;
    localparam int P_CBSA = 1;
    localparam int P_SGCB = 2;
    localparam int P_CGCB = 3;
    localparam int P_CGSA = 4;
    localparam int P_CGCA = 5;
    localparam int P_SGSA = 6;
    localparam int P_SGCA = 7;
    localparam int NUM_P  = 8;

    localparam t_q60 HALF30  = t_q60'(1) << (WORK_FRAC - 1);
    localparam t_q60 HALF_FN = t_q60'(1) << (FIN_SH - 1);
    localparam logic signed [FIN_W-1:0] LIM_P = FIN_W'(OUT_LIM);
    localparam logic signed [FIN_W-1:0] LIM_N = -LIM_P;

    function automatic t_q60 mul_q60(input t_xy a, input t_xy b);
        return t_q60'(a) * t_q60'(b);
    endfunction

    function automatic t_xy rnd_q30(input t_q60 v);
        return XY_W'((v + HALF30) >>> WORK_FRAC);
    endfunction

    function automatic t_ent fin(input t_q60 v);
        logic signed [FIN_W-1:0] w;
        w = FIN_W'((v + HALF_FN) >>> FIN_SH);
        priority if (w > LIM_P) begin
            w = LIM_P;
        end else if (w < LIM_N) begin
            w = LIM_N;
        end else begin
            w = w;
        end
        return OUT_W'(w);
    endfunction

    t_xy    n_c [NUM_ANG];
    t_xy    n_s [NUM_ANG];
    t_xy    r_c [NUM_ANG];
    t_xy    r_s [NUM_ANG];
    t_q60   r_pd1 [NUM_P];
    t_q60   r_pd2 [NUM_P];
    t_q60   r_pd3 [NUM_P];
    t_q60   r_sgsb_p;
    t_q60   r_cgsb_p;
    t_xy    r_sgsb;
    t_xy    r_cgsb;
    t_xy    r_sb1;
    t_xy    r_sb2;
    t_xy    r_sb3;
    t_xy    r_ca1;
    t_xy    r_ca2;
    t_xy    r_sa1;
    t_xy    r_sa2;
    t_q60   r_t [4];
    t_q60   r_e [9];
    t_ent   r_out [9];
    logic [MAT_LAT-1:0] r_vld;

    always_comb begin
        for (int k = 0; k < NUM_ANG; k++) begin
            unique case (i_data.quad[k])
                QUAD_0: begin
                    n_c[k] = i_data.x[k];
                    n_s[k] = i_data.y[k];
                end
                QUAD_1: begin
                    n_c[k] = -i_data.y[k];
                    n_s[k] = i_data.x[k];
                end
                QUAD_2: begin
                    n_c[k] = -i_data.x[k];
                    n_s[k] = -i_data.y[k];
                end
                QUAD_3: begin
                    n_c[k] = i_data.y[k];
                    n_s[k] = -i_data.x[k];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        // fold
        r_c <= n_c;
        r_s <= n_s;
        // first products
        r_pd1[P_CBCA] <= mul_q60(r_c[PITCH], r_c[YAW]);
        r_pd1[P_CBSA] <= mul_q60(r_c[PITCH], r_s[YAW]);
        r_pd1[P_SGCB] <= mul_q60(r_s[ROLL], r_c[PITCH]);
        r_pd1[P_CGCB] <= mul_q60(r_c[ROLL], r_c[PITCH]);
        r_pd1[P_CGSA] <= mul_q60(r_c[ROLL], r_s[YAW]);
        r_pd1[P_CGCA] <= mul_q60(r_c[ROLL], r_c[YAW]);
        r_pd1[P_SGSA] <= mul_q60(r_s[ROLL], r_s[YAW]);
        r_pd1[P_SGCA] <= mul_q60(r_s[ROLL], r_c[YAW]);
        r_sgsb_p      <= mul_q60(r_s[ROLL], r_s[PITCH]);
        r_cgsb_p      <= mul_q60(r_c[ROLL], r_s[PITCH]);
        r_sb1         <= r_s[PITCH];
        r_ca1         <= r_c[YAW];
        r_sa1         <= r_s[YAW];
        // round the three-way partials back to Q.30
        r_pd2  <= r_pd1;
        r_sgsb <= rnd_q30(r_sgsb_p);
        r_cgsb <= rnd_q30(r_cgsb_p);
        r_sb2  <= r_sb1;
        r_ca2  <= r_ca1;
        r_sa2  <= r_sa1;
        // second products
        r_pd3 <= r_pd2;
        r_t[0] <= mul_q60(r_sgsb, r_ca2);
        r_t[1] <= mul_q60(r_sgsb, r_sa2);
        r_t[2] <= mul_q60(r_cgsb, r_ca2);
        r_t[3] <= mul_q60(r_cgsb, r_sa2);
        r_sb3  <= r_sb2;
        // entry sums in Q.60, then rounding and saturation to Q2.14
        r_e[0] <= r_pd3[P_CBCA];
        r_e[1] <= r_pd3[P_CBSA];
        r_e[2] <= -(t_q60'(r_sb3) <<< WORK_FRAC);
        r_e[3] <= r_t[0] - r_pd3[P_CGSA];
        r_e[4] <= r_t[1] + r_pd3[P_CGCA];
        r_e[5] <= r_pd3[P_SGCB];
        r_e[6] <= r_t[2] + r_pd3[P_SGSA];
        r_e[7] <= r_t[3] - r_pd3[P_SGCA];
        r_e[8] <= r_pd3[P_CGCB];
        for (int i = 0; i < 9; i++) begin
            r_out[i] <= fin(r_e[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MAT_LAT-2:0], i_valid};
        end
    end

    assign o_valid   = r_vld[MAT_LAT-1];
    assign o_mat.m00 = r_out[0];
    assign o_mat.m01 = r_out[1];
    assign o_mat.m02 = r_out[2];
    assign o_mat.m10 = r_out[3];
    assign o_mat.m11 = r_out[4];
    assign o_mat.m12 = r_out[5];
    assign o_mat.m20 = r_out[6];
    assign o_mat.m21 = r_out[7];
    assign o_mat.m22 = r_out[8];

endmodule

/* rtl/e2r_obuf.sv */
// e2r_obuf: result FIFO with registered output and a credit count of open transactions.
// Depends on e2r_pkg and e2r_out_if.
module e2r_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_wr,
    input  e2r_pkg::t_mat  i_data,
    output logic           o_room,
    e2r_out_if.source      o_out
);
    import e2r_pkg::*;

    t_mat                r_mem [FIFO_DEPTH];
    t_mat                r_out_data;
    logic                r_out_valid;
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [CREDIT_W-1:0] r_cnt;
    logic [CREDIT_W-1:0] n_cnt;
    logic [CREDIT_W-1:0] r_credit;
    logic [CREDIT_W-1:0] n_credit;
    logic                w_load;
    logic                w_pop;

    assign w_pop  = r_out_valid && o_out.ready;
    assign w_load = (r_cnt != '0) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_cnt    = r_cnt + CREDIT_W'(i_wr) - CREDIT_W'(w_load);
        n_credit = r_credit + CREDIT_W'(i_accept) - CREDIT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= '0;
            r_credit    <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_load) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt    <= n_cnt;
            r_credit <= n_credit;
        end
    end

    assign o_room      = r_credit < CREDIT_W'(FIFO_DEPTH);
    assign o_out.valid = r_out_valid;
    assign o_out.m00   = r_out_data.m00;
    assign o_out.m01   = r_out_data.m01;
    assign o_out.m02   = r_out_data.m02;
    assign o_out.m10   = r_out_data.m10;
    assign o_out.m11   = r_out_data.m11;
    assign o_out.m12   = r_out_data.m12;
    assign o_out.m20   = r_out_data.m20;
    assign o_out.m21   = r_out_data.m21;
    assign o_out.m22   = r_out_data.m22;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking regression for euler_to_rotation_matrix_core; a fixed-point
// Z-Y-X predictor or a table of exact matrices checks every matrix under random idling and long sink hold-offs.
// Depends on e2r_pkg, e2r_if and the core RTL.
module tb_top;
    import e2r_pkg::*;

    localparam int     N_RANDOM    = 1630;
    localparam int     HOLD_CYCLES = 320;
    localparam int     TAIL_CYCLES = 40;
    localparam int     N_STAGES    = 16;
    localparam longint TURN_DEG    = 92160;    // 360 degrees, 8 fraction bits
    localparam longint GAIN_Q30    = 652032874;
    localparam t_ent   P1 = 16'sd16384;
    localparam t_ent   N1 = -16'sd16384;
    localparam t_ent   Z0 = 16'sd0;

    typedef struct {
        t_ang yaw;
        t_ang pitch;
        t_ang roll;
        bit   typed;
        t_mat mat;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    e2r_in_if  in_ch ();
    e2r_out_if out_ch ();

    euler_to_rotation_matrix_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    t_mat  open_matrices [$];
    int    mismatch_count = 0;
    bit    hold_request   = 1'b0;
    bit    src_calm       = 1'b0;
    string field_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    // quarter turns land on exact binary angles; the CORDIC leaves sine within
    // a third of an LSB of zero, and cosine just over 1.0 is clipped
    t_row dir_tab [18] = '{
        '{18'sd0,      18'sd0,      18'sd0,      1'b1, '{P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1}},
        '{18'sd23040,  18'sd0,      18'sd0,      1'b1, '{Z0, P1, Z0, N1, Z0, Z0, Z0, Z0, P1}},
        '{-18'sd23040, 18'sd0,      18'sd0,      1'b1, '{Z0, N1, Z0, P1, Z0, Z0, Z0, Z0, P1}},
        '{18'sd0,      18'sd23040,  18'sd0,      1'b1, '{Z0, Z0, N1, Z0, P1, Z0, P1, Z0, Z0}},
        '{18'sd0,      18'sd46080,  18'sd0,      1'b1, '{N1, Z0, Z0, Z0, P1, Z0, Z0, Z0, N1}},
        '{18'sd0,      18'sd0,      18'sd23040,  1'b1, '{P1, Z0, Z0, Z0, Z0, P1, Z0, N1, Z0}},
        '{18'sd0,      18'sd0,      18'sd46080,  1'b1, '{P1, Z0, Z0, Z0, N1, Z0, Z0, Z0, N1}},
        '{-18'sd46080, 18'sd0,      18'sd0,      1'b1, '{N1, Z0, Z0, Z0, N1, Z0, Z0, Z0, P1}},
        '{18'sd92160,  -18'sd92160, 18'sd92160,  1'b1, '{P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1}},
        '{18'sd131071, 18'sd131071, 18'sd131071, 1'b0, '0},
        '{18'sh20000,  18'sh20000,  18'sh20000,  1'b0, '0},
        '{18'sd92159,  -18'sd1,     18'sd1,      1'b0, '0},
        '{-18'sd92159, 18'sd92158,  18'sd256,    1'b0, '0},
        '{18'sd11520,  18'sd7680,   18'sd15360,  1'b0, '0},
        '{18'sh15555,  18'sh2AAAA,  18'sh15555,  1'b0, '0},
        '{18'sh2AAAA,  18'sh15555,  18'sh2AAAA,  1'b0, '0},
        '{18'sd23039,  18'sd23041,  18'sd46079,  1'b0, '0},
        '{18'sd100000, -18'sd100000, 18'sd120000, 1'b0, '0}
    };

    function automatic longint atan_step(int i);
        case (i)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10679838;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            15:      return 20861;
            default: return 0;
        endcase
    endfunction

    // cosine and sine of one angle, Q.30
    function automatic void angle_to_sincos(input t_ang a, output longint c, output longint s);
        longint     m, p, x, y, z, nx, ny;
        logic [1:0] quad;
        m = longint'(a) % TURN_DEG;
        if (m < 0) m += TURN_DEG;
        p = ((m <<< 32) + TURN_DEG / 2) / TURN_DEG;
        p &= 64'hFFFF_FFFF;
        quad = p[31:30];
        z = p & 64'h3FFF_FFFF;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_step(i);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_step(i);
            end
            x = nx;
            y = ny;
        end
        case (quad)
            QUAD_0:  begin c = x;  s = y;  end
            QUAD_1:  begin c = -y; s = x;  end
            QUAD_2:  begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic t_ent round_q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return t_ent'(r);
    endfunction

    function automatic t_mat zyx_matrix(t_ang yaw, t_ang pitch, t_ang roll);
        longint ca, sa, cb, sb, cg, sg, sgsb, cgsb;
        t_mat   m;
        angle_to_sincos(yaw, ca, sa);
        angle_to_sincos(pitch, cb, sb);
        angle_to_sincos(roll, cg, sg);
        sgsb = (sg * sb + (64'sd1 <<< 29)) >>> 30;
        cgsb = (cg * sb + (64'sd1 <<< 29)) >>> 30;
        m.m00 = round_q14(cb * ca);
        m.m01 = round_q14(cb * sa);
        m.m02 = round_q14(-(sb <<< 30));
        m.m10 = round_q14(sgsb * ca - cg * sa);
        m.m11 = round_q14(sgsb * sa + cg * ca);
        m.m12 = round_q14(sg * cb);
        m.m20 = round_q14(cgsb * ca + sg * sa);
        m.m21 = round_q14(cgsb * sa - sg * ca);
        m.m22 = round_q14(cg * cb);
        return m;
    endfunction

    function automatic t_ang pick_angle();
        int k;
        k = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_ang'($urandom);
            4, 5, 6:    return t_ang'(int'($urandom_range(0, 184320)) - 92160);
            7:          return t_ang'((k - 8) * 11520 + int'($urandom_range(0, 6)) - 3);
            8:          return t_ang'(int'($urandom_range(0, 1024)) - 512);
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 18'sd131071;
                    1:       return 18'sh20000;
                    2:       return 18'sd92160;
                    3:       return -18'sd92160;
                    4:       return 18'sd92159;
                    default: return -18'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_angles(t_ang yaw, t_ang pitch, t_ang roll, bit typed,
                                t_mat typed_mat, bit no_gap);
        int gap;
        @(negedge i_clk);
        in_ch.valid       = 1'b1;
        in_ch.yaw_angle   = yaw;
        in_ch.pitch_angle = pitch;
        in_ch.roll_angle  = roll;
        do @(posedge i_clk); while (!in_ch.ready);
        open_matrices.push_back(typed ? typed_mat : zyx_matrix(yaw, pitch, roll));
        gap = (no_gap || src_calm) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid       = 1'b0;
            in_ch.yaw_angle   = t_ang'($urandom);
            in_ch.pitch_angle = t_ang'($urandom);
            in_ch.roll_angle  = t_ang'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    initial begin : angle_source
        in_ch.valid       = 1'b0;
        in_ch.yaw_angle   = '0;
        in_ch.pitch_angle = '0;
        in_ch.roll_angle  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_tab[r])
            offer_angles(dir_tab[r].yaw, dir_tab[r].pitch, dir_tab[r].roll,
                         dir_tab[r].typed, dir_tab[r].mat, 1'b0);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) src_calm = ($urandom_range(0, 3) == 0);
            if (n == 300 || n == 1100) hold_request = 1'b1;
            // flood while the sink holds off so the result FIFO fills
            offer_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0,
                         (n % 800) >= 300 && (n % 800) < 450);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        wait (open_matrices.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("euler_to_rotation_matrix_core regression: pass");
        else
            $display("euler_to_rotation_matrix_core regression: fail");
        $finish;
    end

    initial begin : matrix_sink
        int stall;
        bit calm;
        stall = 0;
        calm  = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) calm = !calm;
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall -= 1;
            end else begin
                out_ch.ready = 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : matrix_check
        logic [143:0] want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
                   out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22};
            if (open_matrices.size() == 0) begin
                mismatch_count += 1;
                $display("%0t: unexpected matrix transaction, expected none, actual %h",
                         $time, got);
            end else begin
                want = open_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (want[(8-k)*16 +: 16] !== got[(8-k)*16 +: 16]) begin
                        mismatch_count += 1;
                        $display("%0t: %s expected %0d, actual %0d", $time, field_name[k],
                                 $signed(want[(8-k)*16 +: 16]), $signed(got[(8-k)*16 +: 16]));
                    end
            end
        end
    end

    initial begin : watchdog
        #(15_000_000);
        $display("euler_to_rotation_matrix_core regression: fail");
        $finish;
    end

endmodule
